// ----- design/rrde_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrde_pkg
// shared constants, command codes and the corner inset table
// ----------------------------------------------------------------------------
package rrde_pkg;
  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 192;
  localparam int ROW_STRIDE_DEF    = 256;
  localparam int MAX_RADIUS        = 6;

  typedef enum logic [3:0] {
    FN_CLEAR = 4'd0, FN_GRAD = 4'd1, FN_PIXEL = 4'd2, FN_HLINE = 4'd3,
    FN_VLINE = 4'd4, FN_RECT = 4'd5, FN_FILL = 4'd6, FN_FROUND = 4'd7,
    FN_ROUTL = 4'd8, FN_READ = 4'd9
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEG, ST_RUN, ST_READ, ST_RDWAIT, ST_OUT
  } state_t;

  function automatic logic [2:0] inset_f(input logic [2:0] r, input logic [2:0] j);
    logic [2:0] v;
    v = 3'd0;
    case (r)
      3'd2: if (j == 3'd0) v = 3'd1;
      3'd3, 3'd4: begin
        if (j == 3'd0) v = 3'd2;
        else if (j == 3'd1) v = 3'd1;
      end
      3'd5: begin
        if (j == 3'd0) v = 3'd3;
        else if (j == 3'd1 || j == 3'd2) v = 3'd1;
      end
      3'd6: begin
        if (j == 3'd0) v = 3'd3;
        else if (j == 3'd1) v = 3'd2;
        else if (j == 3'd2 || j == 3'd3) v = 3'd1;
      end
      default: v = 3'd0;
    endcase
    return v;
  endfunction
endpackage

// ----- design/rounded_rect_draw_engine_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_draw_engine_core
// command rasteriser writing a 16-bit frame memory one pixel a cycle
// ----------------------------------------------------------------------------
// sequence: each segment gets a settling and a latch step in ST_SEG, each pixel
// of its clipped runs is written in ST_RUN, and ST_OUT loads the result beat
// throughput: one pixel per cycle through the single frame memory write port;
// a read passes ST_SEG, ST_READ, ST_RDWAIT and ST_OUT before its beat appears;
// next command can be taken as the beat appears; a held beat stalls the next one
// reset: synchronous active-low rst_n clears control only; memory is undefined
module rounded_rect_draw_engine_core #(
  parameter int SCREEN_WIDTH  = rrde_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rrde_pkg::SCREEN_HEIGHT_DEF,
  parameter int ROW_STRIDE    = rrde_pkg::ROW_STRIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // func[3:0] pos_x[14:4] pos_y[25:15] width[35:26] height[45:36]
  // radius[49:46] color[65:50] color_bottom[81:66], zero fill to 88
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_data[15:0] read_hit[16], zero fill to 24
  output logic [23:0] out_tdata
);
  import rrde_pkg::*;

  localparam int DEPTH = ROW_STRIDE * SCREEN_HEIGHT + SCREEN_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int HM    = SCREEN_HEIGHT - 1;
  localparam int RSH   = 26;
  localparam logic [22:0] RECIP = 23'(((64'd1 << RSH) + 64'(HM) - 64'd1) / 64'(HM));

  logic [15:0] mem [DEPTH];

  state_t      state_r, state_nxt;
  logic [3:0]  func_r;
  logic signed [12:0] x_r, y_r;
  logic signed [12:0] w_r, h_r;
  logic [2:0]  rad_r;
  logic [15:0] col_r, colb_r;
  logic [5:0]  seg_r, seg_nxt;
  logic        seg_last_r, seg_last_nxt;
  // current run
  logic        vert_r;
  logic signed [12:0] rx_r, ry_r, rcnt_r;
  logic [15:0] rcol_r;
  logic [15:0] rd_r;
  logic        hit_r;
  logic [15:0] qdata_r;
  logic        wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0] odata_r;
  logic        ohit_r;

  // gradient channel math (registered per row)
  logic [4:0]  rt, gt, bt, rb, gb, bb;
  logic signed [17:0] dr, dg, db;
  logic signed [17:0] prod_r [3];
  logic signed [17:0] ydiv;

  // segment generator
  logic        s_valid, s_vert, s_last;
  logic signed [12:0] s_x, s_y, s_len;
  logic [15:0] s_col;

  logic [2:0] rc;
  logic signed [12:0] r2;
  logic [2:0] jseg, ins, prv, endk;
  logic [1:0] q;
  logic signed [12:0] wm1, hm1;

  // top + p / HM truncated toward zero, by reciprocal multiplication
  function automatic logic [4:0] grad_step(input logic [4:0] top, input logic signed [17:0] p);
    logic [14:0] mag;
    logic [37:0] prd;
    logic [4:0]  qt;
    mag = p[17] ? 15'(-p) : p[14:0];
    prd = {23'd0, mag} * {15'd0, RECIP};
    qt = prd[RSH+4:RSH];
    return p[17] ? top - qt : top + qt;
  endfunction

  always_comb begin
    logic signed [12:0] t;
    rc = (rad_r > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : rad_r;
    t = $signed({10'd0, rc}) <<< 1;
    if (t > w_r) rc = w_r[3:1];
    t = $signed({10'd0, rc}) <<< 1;
    if (t > h_r) rc = h_r[3:1];
    r2 = $signed({10'd0, rc}) <<< 1;
  end

  assign wm1 = w_r - 13'sd1;
  assign hm1 = h_r - 13'sd1;
  assign jseg = seg_r[4:2];
  assign q = seg_r[1:0];
  assign ins = inset_f(rc, jseg);
  assign prv = (jseg == 3'd0) ? rc : inset_f(rc, jseg - 3'd1);
  assign endk = (prv > ins) ? prv : ins + 3'd1;

  // shared row-driven runs: clear, gradient, fill and fill round count rows in row_r
  logic [9:0] row_r, row_nxt;
  logic signed [12:0] row_j;
  logic [2:0] fins;
  assign row_j = $signed({3'd0, row_r});
  always_comb begin
    fins = 3'd0;
    if (func_r == FN_FROUND) begin
      if (row_j < $signed({10'd0, rc})) fins = inset_f(rc, row_j[2:0]);
      else if (row_j >= h_r - $signed({10'd0, rc}))
        fins = inset_f(rc, 3'(h_r - 13'sd1 - row_j));
    end
  end

  always_comb begin
    s_valid = 1'b0; s_vert = 1'b0; s_last = 1'b0;
    s_x = '0; s_y = '0; s_len = '0; s_col = col_r;
    seg_nxt = seg_r + 6'd1;
    row_nxt = row_r;
    case (func_r)
      FN_CLEAR, FN_GRAD: begin
        s_valid = 1'b1; s_x = '0; s_y = $signed({3'd0, row_r});
        s_len = 13'(SCREEN_WIDTH);
        s_last = (row_r == 10'(HM));
        row_nxt = row_r + 10'd1; seg_nxt = seg_r;
        if (func_r == FN_GRAD)
          s_col = 16'h8000 | {1'b0, grad_step(bt, prod_r[2]), grad_step(gt, prod_r[1]),
                              grad_step(rt, prod_r[0])};
      end
      FN_PIXEL: begin
        s_valid = 1'b1; s_x = x_r; s_y = y_r; s_len = 13'sd1; s_last = 1'b1;
      end
      FN_HLINE: begin
        s_valid = 1'b1; s_x = x_r; s_y = y_r; s_len = w_r; s_last = 1'b1;
      end
      FN_VLINE: begin
        s_valid = 1'b1; s_vert = 1'b1; s_x = x_r; s_y = y_r; s_len = h_r; s_last = 1'b1;
      end
      FN_RECT: begin
        s_valid = 1'b1;
        case (seg_r[1:0])
          2'd0: begin s_x = x_r; s_y = y_r; s_len = w_r; end
          2'd1: begin s_x = x_r; s_y = y_r + hm1; s_len = w_r; end
          2'd2: begin s_vert = 1'b1; s_x = x_r; s_y = y_r; s_len = h_r; end
          default: begin
            s_vert = 1'b1; s_x = x_r + wm1; s_y = y_r; s_len = h_r; s_last = 1'b1;
          end
        endcase
      end
      FN_FILL, FN_FROUND: begin
        s_valid = (h_r != 0);
        s_x = x_r + $signed({10'd0, fins});
        s_y = y_r + row_j;
        s_len = w_r - ($signed({10'd0, fins}) <<< 1);
        s_last = (h_r == 0) || (row_j == hm1);
        row_nxt = row_r + 10'd1;
      end
      FN_ROUTL: begin
        s_valid = 1'b1;
        if (!seg_r[5]) begin
          // straight edges in slots 0..3, then corners from 32
          case (seg_r[1:0])
            2'd0: begin s_x = x_r + $signed({10'd0, rc}); s_y = y_r; s_len = w_r - r2; end
            2'd1: begin s_x = x_r + $signed({10'd0, rc}); s_y = y_r + hm1; s_len = w_r - r2; end
            2'd2: begin
              s_vert = 1'b1; s_x = x_r; s_y = y_r + $signed({10'd0, rc}); s_len = h_r - r2;
            end
            default: begin
              s_vert = 1'b1; s_x = x_r + wm1; s_y = y_r + $signed({10'd0, rc});
              s_len = h_r - r2;
              s_last = (rc == 3'd0);
              seg_nxt = 6'd32;
            end
          endcase
        end else begin
          // corner arc run of width endk-ins; each quadrant drawn as short hrun
          s_len = $signed({10'd0, endk - ins});
          case (q)
            2'd0: begin s_x = x_r + $signed({10'd0, ins}); s_y = y_r + $signed({10'd0, jseg}); end
            2'd1: begin
              s_x = x_r + wm1 - $signed({10'd0, endk}) + 13'sd1; s_y = y_r + $signed({10'd0, jseg});
            end
            2'd2: begin s_x = x_r + $signed({10'd0, ins}); s_y = y_r + hm1 - $signed({10'd0, jseg}); end
            default: begin
              s_x = x_r + wm1 - $signed({10'd0, endk}) + 13'sd1;
              s_y = y_r + hm1 - $signed({10'd0, jseg});
            end
          endcase
          s_last = (q == 2'd3) && (jseg == rc - 3'd1);
        end
      end
      default: begin
        s_valid = 1'b0; s_last = 1'b1;
      end
    endcase
  end

  // clip the segment
  logic signed [12:0] c_x, c_y, c_len;
  logic c_ok;
  always_comb begin
    c_x = s_x; c_y = s_y; c_len = s_len; c_ok = s_valid;
    if (s_vert) begin
      if (s_x < 0 || s_x >= 13'(SCREEN_WIDTH)) c_ok = 1'b0;
      if (s_y < 0) begin c_len = s_len + s_y; c_y = '0; end
      if (c_y + c_len > 13'(SCREEN_HEIGHT)) c_len = 13'(SCREEN_HEIGHT) - c_y;
    end else begin
      if (s_y < 0 || s_y >= 13'(SCREEN_HEIGHT)) c_ok = 1'b0;
      if (s_x < 0) begin c_len = s_len + s_x; c_x = '0; end
      if (c_x + c_len > 13'(SCREEN_WIDTH)) c_len = 13'(SCREEN_WIDTH) - c_x;
    end
    if (c_len <= 0) c_ok = 1'b0;
  end

  assign rt = col_r[4:0];   assign gt = col_r[9:5];   assign bt = col_r[14:10];
  assign rb = colb_r[4:0];  assign gb = colb_r[9:5];  assign bb = colb_r[14:10];
  assign dr = 18'($signed({1'b0, rb}) - $signed({1'b0, rt}));
  assign dg = 18'($signed({1'b0, gb}) - $signed({1'b0, gt}));
  assign db = 18'($signed({1'b0, bb}) - $signed({1'b0, bt}));
  assign ydiv = $signed({8'd0, row_r});

  always_ff @(posedge clk) begin
    prod_r[0] <= dr * ydiv;
    prod_r[1] <= dg * ydiv;
    prod_r[2] <= db * ydiv;
  end

  // settling step in ST_SEG for the gradient product before each segment is latched
  logic pre_r, pre_nxt;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    wr_en = 1'b0;
    pre_nxt = pre_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_SEG;
          pre_nxt = 1'b1;
        end
      end
      ST_SEG: begin
        if (func_r == FN_READ) state_nxt = ST_READ;
        else if (pre_r) pre_nxt = 1'b0;
        else if (c_ok) state_nxt = ST_RUN;
        else if (s_last) state_nxt = ST_OUT;
        else pre_nxt = 1'b1;
      end
      ST_RUN: begin
        wr_en = 1'b1;
        if (rcnt_r == 13'sd1) begin
          state_nxt = seg_last_r ? ST_OUT : ST_SEG;
          pre_nxt = 1'b1;
        end
      end
      ST_READ:   state_nxt = ST_RDWAIT;
      ST_RDWAIT: state_nxt = ST_OUT;
      ST_OUT:    if (!out_tvalid || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign wr_addr = AW'(ry_r) * AW'(ROW_STRIDE) + AW'(rx_r);
  assign rd_addr = AW'(y_r) * AW'(ROW_STRIDE) + AW'(x_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= rcol_r;
    qdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_tvalid <= 1'b0;
      pre_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      pre_r <= pre_nxt;
      if (state_r == ST_OUT && state_nxt == ST_IDLE) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;
    end
  end

  assign seg_last_nxt = s_last;

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      func_r <= in_tdata[3:0];
      x_r <= 13'(signed'(in_tdata[14:4]));
      y_r <= 13'(signed'(in_tdata[25:15]));
      w_r <= $signed({3'd0, in_tdata[35:26]});
      h_r <= $signed({3'd0, in_tdata[45:36]});
      rad_r <= (in_tdata[49:46] > 4'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : in_tdata[48:46];
      col_r <= in_tdata[65:50];
      colb_r <= in_tdata[81:66];
      seg_r <= '0;
      row_r <= '0;
      rd_r <= '0;
      hit_r <= 1'b0;
    end
    if (state_r == ST_SEG && !pre_r && func_r != FN_READ) begin
      seg_r <= seg_nxt; row_r <= row_nxt; seg_last_r <= seg_last_nxt;
      vert_r <= s_vert; rx_r <= c_x; ry_r <= c_y; rcnt_r <= c_len; rcol_r <= s_col;
    end
    if (state_r == ST_RUN) begin
      rcnt_r <= rcnt_r - 13'sd1;
      if (vert_r) ry_r <= ry_r + 13'sd1;
      else rx_r <= rx_r + 13'sd1;
    end
    if (state_r == ST_RDWAIT) begin
      if (x_r >= 0 && x_r < 13'(SCREEN_WIDTH) && y_r >= 0 && y_r < 13'(SCREEN_HEIGHT)) begin
        hit_r <= 1'b1; rd_r <= qdata_r;
      end
    end
    if (state_r == ST_OUT && state_nxt == ST_IDLE) begin
      odata_r <= rd_r; ohit_r <= hit_r;
    end
  end

  assign out_tdata = {7'd0, ohit_r, odata_r};

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !wr_en) else $error("write while idle");
  a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> rcnt_r > 0) else $error("empty run");
endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives draw commands into rounded_rect_draw_engine_core, keeps a shadow
// frame buffer that it paints the same way, and checks each result beat
// against it in order, under random gaps and back-pressure on both streams
// ----------------------------------------------------------------------------
module testbench;
  import rrde_pkg::*;

  localparam int SW = SCREEN_WIDTH_DEF;
  localparam int SH = SCREEN_HEIGHT_DEF;
  localparam int WATCHDOG_LIMIT = 300000;

  typedef struct {
    logic [3:0]  func;
    int          px;
    int          py;
    int          w;
    int          h;
    int          r;
    logic [15:0] c;
    logic [15:0] cb;
    bit          sync;
  } draw_cmd_t;

  typedef struct {
    logic [15:0] data;
    logic        hit;
  } read_res_t;

  localparam int CORNER_INSET [0:6][0:6] = '{
    '{0, 0, 0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0, 0, 0}, '{1, 0, 0, 0, 0, 0, 0},
    '{2, 1, 0, 0, 0, 0, 0}, '{2, 1, 0, 0, 0, 0, 0}, '{3, 1, 1, 0, 0, 0, 0},
    '{3, 2, 1, 1, 0, 0, 0}};

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  logic [15:0] shadow_fb [0:SW*SH-1];
  draw_cmd_t   pending_cmds[$];
  read_res_t   expected_reads[$];
  draw_cmd_t   cur_cmd;
  int          cmd_count [0:15];
  int          sent, beats_seen, errors, tx_gap, rx_gap, long_hold, idle_cycles;
  bit          nv;

  rounded_rect_draw_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  // shadow frame buffer painting
  function automatic void plot(int x, int y, logic [15:0] c);
    if (x >= 0 && x < SW && y >= 0 && y < SH) shadow_fb[y*SW + x] = c;
  endfunction

  function automatic void span_h(int x, int y, int w, logic [15:0] c);
    if (y < 0 || y >= SH) return;
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (x + w > SW) w = SW - x;
    for (int i = 0; i < w; i++) plot(x + i, y, c);
  endfunction

  function automatic void span_v(int x, int y, int h, logic [15:0] c);
    if (x < 0 || x >= SW) return;
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (y + h > SH) h = SH - y;
    for (int i = 0; i < h; i++) plot(x, y + i, c);
  endfunction

  function automatic int limit_radius(int r, int w, int h);
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    if (r * 2 > w) r = w / 2;
    if (r * 2 > h) r = h / 2;
    return r;
  endfunction

  function automatic read_res_t paint_command(draw_cmd_t d);
    read_res_t res;
    int r, ins, prev, stop, rt, gt, bt, rb, gb, bb, cr, cg, cbl;
    res.data = '0;
    res.hit = 1'b0;
    case (d.func)
      FN_CLEAR: for (int j = 0; j < SH; j++) span_h(0, j, SW, d.c);
      FN_GRAD: begin
        rt = d.c[4:0];   gt = d.c[9:5];   bt = d.c[14:10];
        rb = d.cb[4:0];  gb = d.cb[9:5];  bb = d.cb[14:10];
        for (int y = 0; y < SH; y++) begin
          cr  = rt + (rb - rt) * y / (SH - 1);
          cg  = gt + (gb - gt) * y / (SH - 1);
          cbl = bt + (bb - bt) * y / (SH - 1);
          span_h(0, y, SW, {1'b1, cbl[4:0], cg[4:0], cr[4:0]});
        end
      end
      FN_PIXEL: plot(d.px, d.py, d.c);
      FN_HLINE: span_h(d.px, d.py, d.w, d.c);
      FN_VLINE: span_v(d.px, d.py, d.h, d.c);
      FN_RECT: begin
        span_h(d.px, d.py, d.w, d.c);
        span_h(d.px, d.py + d.h - 1, d.w, d.c);
        span_v(d.px, d.py, d.h, d.c);
        span_v(d.px + d.w - 1, d.py, d.h, d.c);
      end
      FN_FILL: for (int j = 0; j < d.h; j++) span_h(d.px, d.py + j, d.w, d.c);
      FN_FROUND: begin
        r = limit_radius(d.r, d.w, d.h);
        for (int j = 0; j < d.h; j++) begin
          ins = 0;
          if (j < r) ins = CORNER_INSET[r][j];
          else if (j >= d.h - r) ins = CORNER_INSET[r][d.h - 1 - j];
          span_h(d.px + ins, d.py + j, d.w - 2 * ins, d.c);
        end
      end
      FN_ROUTL: begin
        r = limit_radius(d.r, d.w, d.h);
        span_h(d.px + r, d.py, d.w - 2 * r, d.c);
        span_h(d.px + r, d.py + d.h - 1, d.w - 2 * r, d.c);
        span_v(d.px, d.py + r, d.h - 2 * r, d.c);
        span_v(d.px + d.w - 1, d.py + r, d.h - 2 * r, d.c);
        for (int j = 0; j < r; j++) begin
          ins  = CORNER_INSET[r][j];
          prev = (j > 0) ? CORNER_INSET[r][j - 1] : r;
          stop = (prev > ins) ? prev : ins + 1;
          for (int k = ins; k < stop; k++) begin
            plot(d.px + k, d.py + j, d.c);
            plot(d.px + d.w - 1 - k, d.py + j, d.c);
            plot(d.px + k, d.py + d.h - 1 - j, d.c);
            plot(d.px + d.w - 1 - k, d.py + d.h - 1 - j, d.c);
          end
        end
      end
      FN_READ: if (d.px >= 0 && d.px < SW && d.py >= 0 && d.py < SH) begin
        res.hit = 1'b1;
        res.data = shadow_fb[d.py*SW + d.px];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [87:0] pack_cmd(draw_cmd_t d);
    logic [10:0] x, y;
    x = d.px[10:0];
    y = d.py[10:0];
    return {6'd0, d.cb, d.c, d.r[3:0], d.h[9:0], d.w[9:0], y, x, d.func};
  endfunction

  function automatic draw_cmd_t mk_cmd(logic [3:0] f, int x, int y, int w, int h, int r,
                                       logic [15:0] c, logic [15:0] cb);
    draw_cmd_t d;
    d.func = f; d.px = x; d.py = y; d.w = w; d.h = h; d.r = r;
    d.c = c; d.cb = cb; d.sync = 0;
    return d;
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t d;
    int sel;
    sel = $urandom_range(0, 999);
    d = mk_cmd(FN_READ, int'($urandom_range(0, 299)) - 20, int'($urandom_range(0, 235)) - 20,
               $urandom_range(0, 40), $urandom_range(0, 40), $urandom_range(0, 15),
               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    if (sel < 2) d.func = FN_CLEAR;
    else if (sel < 4) d.func = FN_GRAD;
    else if (sel < 30) d.func = 4'($urandom_range(10, 15));
    else if (sel < 380) d.func = FN_READ;
    else d.func = 4'($urandom_range(FN_PIXEL, FN_ROUTL));
    if ($urandom_range(0, 19) == 0) begin
      d.px = int'($urandom_range(0, 2047)) - 1024;
      d.py = int'($urandom_range(0, 2047)) - 1024;
    end
    // long spans mostly on the cheap primitives
    if ($urandom_range(0, 9) == 0 && d.func inside {FN_HLINE, FN_VLINE, FN_RECT, FN_ROUTL,
                                                     FN_PIXEL, FN_READ}) begin
      d.w = $urandom_range(0, 1023);
      d.h = $urandom_range(0, 1023);
    end else if ($urandom_range(0, 199) == 0) begin
      d.w = $urandom_range(0, 1023);
      d.h = $urandom_range(0, 1023);
    end
    return d;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        expected_reads.push_back(paint_command(cur_cmd));
        cmd_count[cur_cmd.func]++;
        sent++;
        nv = 0;
      end
      if (!nv) begin
        if (tx_gap > 0) tx_gap--;
        else if (pending_cmds.size() > 0 && !(pending_cmds[0].sync && expected_reads.size() > 0))
        begin
          cur_cmd = pending_cmds.pop_front();
          in_tdata <= pack_cmd(cur_cmd);
          nv = 1;
          if ((sent / 250) % 4 == 3) tx_gap = 0;
          else if ($urandom_range(0, 29) == 0) tx_gap = $urandom_range(20, 80);
          else if ($urandom_range(0, 2) == 0) tx_gap = $urandom_range(1, 3);
          else tx_gap = 0;
        end
      end
      in_tvalid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    read_res_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        beats_seen++;
        if (beats_seen == 300) long_hold = 3000;
        if (expected_reads.size() == 0) begin
          $error("unexpected beat: read_data %h read_hit %b", out_tdata[15:0], out_tdata[16]);
          errors++;
        end else begin
          e = expected_reads.pop_front();
          if (out_tdata[15:0] !== e.data) begin
            $error("read_data expected %h actual %h", e.data, out_tdata[15:0]);
            errors++;
          end
          if (out_tdata[16] !== e.hit) begin
            $error("read_hit expected %b actual %b", e.hit, out_tdata[16]);
            errors++;
          end
        end
      end
      if (long_hold > 0) begin
        long_hold--;
        out_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ((beats_seen / 250) % 4 != 1) begin
          if ($urandom_range(0, 59) == 0) rx_gap = $urandom_range(20, 60);
          else if ($urandom_range(0, 5) == 0) rx_gap = $urandom_range(1, 3);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d beats still owed", expected_reads.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    draw_cmd_t d;
    int total_cmds;
    clk = 0; rst_n = 0; in_tvalid = 0; in_tdata = '0; out_tready = 0;
    sent = 0; beats_seen = 0; errors = 0; tx_gap = 0; rx_gap = 0;
    long_hold = 0; idle_cycles = 0;
    foreach (cmd_count[i]) cmd_count[i] = 0;

    // clear first so every later in-range read hits written memory
    pending_cmds.push_back(mk_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 16'h1234, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 0, 0, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_GRAD, 0, 0, 0, 0, 0, 16'h7FFF, 16'h8000));
    pending_cmds.push_back(mk_cmd(FN_READ, 255, 191, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 3, 96, 1023, 1023, 15, 16'hFFFF, 16'hFFFF));
    pending_cmds.push_back(mk_cmd(FN_PIXEL, 255, 0, 0, 0, 0, 16'hFFFF, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 255, 0, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 256, 0, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, -1, 5, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 0, 192, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, -1024, 1023, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_HLINE, -1024, 10, 1023, 0, 0, 16'h0F0F, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_VLINE, 20, -5, 0, 1023, 0, 16'hF0F0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_RECT, 30, 30, 0, 5, 0, 16'h00AA, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_RECT, 40, 30, 6, 0, 0, 16'h00BB, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 29, 30, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 40, 29, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_FILL, 250, 185, 20, 20, 0, 16'h5555, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_FROUND, 60, 60, 20, 9, 15, 16'h3333, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 60, 60, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_ROUTL, 100, 100, 14, 14, 6, 16'h4444, 16'h0));
    pending_cmds.push_back(mk_cmd(FN_READ, 103, 100, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(4'd15, 0, 0, 0, 0, 0, 16'h0, 16'h0));
    pending_cmds.push_back(mk_cmd(4'd10, 0, 0, 0, 0, 0, 16'h0, 16'h0));

    for (int i = 0; i < 1750; i++) begin
      d = rand_cmd();
      // one send that waits for the result stream to drain
      if (i == 900) d.sync = 1;
      // burst of cheap commands around the long receiver hold-off
      if (i >= 250 && i < 330) d.func = ($urandom_range(0, 1) == 0) ? FN_READ : FN_PIXEL;
      pending_cmds.push_back(d);
    end
    total_cmds = pending_cmds.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    wait (sent == total_cmds);
    wait (expected_reads.size() == 0);
    repeat (50) @(posedge clk);
    $display("%0d commands, %0d result beats: clear %0d gradient %0d read %0d",
             sent, beats_seen, cmd_count[FN_CLEAR], cmd_count[FN_GRAD], cmd_count[FN_READ]);
    $display("fill %0d rounded fill %0d rounded outline %0d, %0d errors",
             cmd_count[FN_FILL], cmd_count[FN_FROUND], cmd_count[FN_ROUTL], errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/rrde_pkg.sv
design/rounded_rect_draw_engine_core.sv
sim/testbench.sv
